[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, sampled on the rising edge, off while reset is held.
`define ASSERT_CLK(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/cau_pkg.sv]
`timescale 1ns / 1ps

package cau_pkg;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_NEG = 3'd4,
        OP_CMP = 3'd5
    } op_t;

    localparam int QBITS = 33;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MAX = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] val;
        logic        ov;
    } sat_t;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        eq;
        logic        dz;
        logic        ov;
    } res_t;

    // one lane of the restoring divider, quotient in sign-magnitude form
    typedef struct packed {
        logic             neg;
        logic             big;
        logic [63:0]      mag;
        logic [63:0]      rem;
        logic [QBITS-1:0] q;
    } div_lane_t;

    typedef struct packed {
        logic [2:0]  op;
        res_t        res;
        logic [63:0] den;
        div_lane_t   lre;
        div_lane_t   lim;
    } stage_t;

    function automatic sat_t sat33(logic [32:0] v);
        sat_t r;
        r.ov  = v[32] != v[31];
        r.val = r.ov ? (v[32] ? NEG_MAX : POS_MAX) : v[31:0];
        return r;
    endfunction

    function automatic sat_t sat65(logic [64:0] v);
        sat_t r;
        r.ov  = !((&v[64:31]) || !(|v[64:31]));
        r.val = r.ov ? (v[64] ? NEG_MAX : POS_MAX) : v[31:0];
        return r;
    endfunction

    function automatic sat_t sat_sm(logic neg, logic big, logic [QBITS-1:0] q);
        sat_t r;
        if (!neg) begin
            r.ov  = big || (q > {1'b0, POS_MAX});
            r.val = r.ov ? POS_MAX : q[31:0];
        end else begin
            r.ov  = big || (q > {1'b0, NEG_MAX});
            r.val = r.ov ? NEG_MAX : 32'(-q);
        end
        return r;
    endfunction

    function automatic div_lane_t lane_step(div_lane_t l, logic [63:0] den, logic nbit);
        div_lane_t   r;
        logic [64:0] t;
        logic [64:0] d;
        r = l;
        t = {l.rem, nbit};
        d = {1'b0, den};
        if (t >= d) begin
            r.rem = 64'(t - d);
            r.q   = {l.q[QBITS-2:0], 1'b1};
        end else begin
            r.rem = t[63:0];
            r.q   = {l.q[QBITS-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic stage_t div_stage(stage_t s, logic nre, logic nim);
        stage_t r;
        r     = s;
        r.lre = lane_step(s.lre, s.den, nre);
        r.lim = lane_step(s.lim, s.den, nim);
        return r;
    endfunction

endpackage

[rtl/complex_arithmetic_unit.sv]
// Complex ALU on signed fixed point (FRAC_BITS fraction bits, 32 bits per part): add, subtract,
// multiply, divide, negate a and exact compare, one result per transaction with saturation.
// Fully pipelined: one transaction per cycle while s_ready is high, through three stages of
// products, sums and setup, 33 restoring-divider stages and an output register; the divider
// stages set the depth and every operation walks the same path. When m_ready is low as a result
// reaches the held output, a one-entry skid register catches it and the whole pipeline holds
// from the next cycle on, with s_ready low, until it drains. No configuration, no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module complex_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_operation,
    input  logic signed [31:0] s_a_re,
    input  logic signed [31:0] s_a_im,
    input  logic signed [31:0] s_b_re,
    input  logic signed [31:0] s_b_im,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_res_re,
    output logic signed [31:0] m_res_im,
    output logic               m_equal_flag,
    output logic               m_div_zero,
    output logic               m_overflow
);

    localparam int DEPTH = cau_pkg::QBITS;
    localparam int SH    = cau_pkg::QBITS - FRAC_BITS;

    logic en;
    logic skid_full_reg;

    // stage 1: products
    logic               v1_reg;
    logic [2:0]         op1_reg;
    logic signed [31:0] ar1_reg, ai1_reg, br1_reg, bi1_reg;
    logic signed [63:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, d_rr_reg, d_ii_reg;

    // stage 2: sums and the simple operations
    logic               v2_reg;
    logic [2:0]         op2_reg;
    cau_pkg::res_t      res2_reg, res2_next;
    logic signed [64:0] mre2_reg, mim2_reg, dre2_reg, dim2_reg;
    logic [63:0]        den2_reg;

    // stage 3 and divider stages
    cau_pkg::stage_t    pipe_reg  [0:DEPTH];
    cau_pkg::stage_t    pipe_next [0:DEPTH];
    cau_pkg::stage_t    st3_next;
    logic [DEPTH:0]     pv_reg;

    cau_pkg::res_t      fin;
    cau_pkg::res_t      out_reg, skid_reg;
    logic               m_valid_reg;

    assign en      = !skid_full_reg;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            pv_reg <= '0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            pv_reg <= {pv_reg[DEPTH-1:0], v2_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op1_reg  <= s_operation;
            ar1_reg  <= s_a_re;
            ai1_reg  <= s_a_im;
            br1_reg  <= s_b_re;
            bi1_reg  <= s_b_im;
            p_rr_reg <= s_a_re * s_b_re;
            p_ii_reg <= s_a_im * s_b_im;
            p_ri_reg <= s_a_re * s_b_im;
            p_ir_reg <= s_a_im * s_b_re;
            d_rr_reg <= s_b_re * s_b_re;
            d_ii_reg <= s_b_im * s_b_im;

            op2_reg  <= op1_reg;
            res2_reg <= res2_next;
            mre2_reg <= $signed({p_rr_reg[63], p_rr_reg}) - $signed({p_ii_reg[63], p_ii_reg});
            mim2_reg <= $signed({p_ri_reg[63], p_ri_reg}) + $signed({p_ir_reg[63], p_ir_reg});
            dre2_reg <= $signed({p_rr_reg[63], p_rr_reg}) + $signed({p_ii_reg[63], p_ii_reg});
            dim2_reg <= $signed({p_ir_reg[63], p_ir_reg}) - $signed({p_ri_reg[63], p_ri_reg});
            den2_reg <= 64'(d_rr_reg) + 64'(d_ii_reg);

            for (int i = 0; i <= DEPTH; i++) begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
    end

    always_comb begin
        cau_pkg::sat_t sr;
        cau_pkg::sat_t si;
        res2_next = '0;
        sr        = '0;
        si        = '0;
        unique case (op1_reg)
            cau_pkg::OP_ADD: begin
                sr = cau_pkg::sat33({ar1_reg[31], ar1_reg} + {br1_reg[31], br1_reg});
                si = cau_pkg::sat33({ai1_reg[31], ai1_reg} + {bi1_reg[31], bi1_reg});
            end
            cau_pkg::OP_SUB: begin
                sr = cau_pkg::sat33({ar1_reg[31], ar1_reg} - {br1_reg[31], br1_reg});
                si = cau_pkg::sat33({ai1_reg[31], ai1_reg} - {bi1_reg[31], bi1_reg});
            end
            cau_pkg::OP_NEG: begin
                sr = cau_pkg::sat33(33'd0 - {ar1_reg[31], ar1_reg});
                si = cau_pkg::sat33(33'd0 - {ai1_reg[31], ai1_reg});
            end
            cau_pkg::OP_CMP: res2_next.eq = (ar1_reg == br1_reg) && (ai1_reg == bi1_reg);
            default: ;
        endcase
        res2_next.re = sr.val;
        res2_next.im = si.val;
        res2_next.ov = sr.ov | si.ov;
    end

    // sign-magnitude numerator and integer-part overflow check for one divider lane
    function automatic cau_pkg::div_lane_t init_lane(logic signed [64:0] v, logic [63:0] den);
        cau_pkg::div_lane_t l;
        logic [63:0]        top;
        l.neg = v[64];
        l.mag = v[64] ? 64'(-v) : v[63:0];
        top   = l.mag >> SH;
        l.big = top >= den;
        l.rem = top;
        l.q   = '0;
        return l;
    endfunction

    always_comb begin
        cau_pkg::sat_t sr;
        cau_pkg::sat_t si;
        logic signed [64:0] shr;
        logic signed [64:0] shi;
        shr          = mre2_reg >>> FRAC_BITS;
        shi          = mim2_reg >>> FRAC_BITS;
        sr           = cau_pkg::sat65(shr);
        si           = cau_pkg::sat65(shi);
        st3_next.op  = op2_reg;
        st3_next.den = den2_reg;
        st3_next.lre = init_lane(dre2_reg, den2_reg);
        st3_next.lim = init_lane(dim2_reg, den2_reg);
        st3_next.res = res2_reg;
        if (op2_reg == cau_pkg::OP_MUL) begin
            st3_next.res.re = sr.val;
            st3_next.res.im = si.val;
            st3_next.res.ov = sr.ov | si.ov;
        end
    end

    assign pipe_next[0] = st3_next;

    // stage j brings down numerator bit K of mag * 2^FRAC_BITS
    for (genvar j = 0; j < DEPTH; j++) begin : g_div
        localparam int K = DEPTH - 1 - j;
        logic nre, nim;
        if (K >= FRAC_BITS) begin : g_bit
            assign nre = pipe_reg[j].lre.mag[K-FRAC_BITS];
            assign nim = pipe_reg[j].lim.mag[K-FRAC_BITS];
        end else begin : g_zero
            assign nre = 1'b0;
            assign nim = 1'b0;
        end
        assign pipe_next[j+1] = cau_pkg::div_stage(pipe_reg[j], nre, nim);
    end

    always_comb begin
        cau_pkg::sat_t sr;
        cau_pkg::sat_t si;
        sr  = cau_pkg::sat_sm(pipe_reg[DEPTH].lre.neg, pipe_reg[DEPTH].lre.big,
                              pipe_reg[DEPTH].lre.q);
        si  = cau_pkg::sat_sm(pipe_reg[DEPTH].lim.neg, pipe_reg[DEPTH].lim.big,
                              pipe_reg[DEPTH].lim.q);
        fin = pipe_reg[DEPTH].res;
        if (pipe_reg[DEPTH].op == cau_pkg::OP_DIV) begin
            fin = '0;
            if (pipe_reg[DEPTH].den == '0) begin
                fin.dz = 1'b1;
            end else begin
                fin.re = sr.val;
                fin.im = si.val;
                fin.ov = sr.ov | si.ov;
            end
        end
    end

    // output register plus one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (skid_full_reg) begin
            if (m_ready) begin
                skid_full_reg <= 1'b0;
            end
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= pv_reg[DEPTH];
        end else if (pv_reg[DEPTH]) begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_full_reg) begin
            if (m_ready) begin
                out_reg <= skid_reg;
            end
        end else if (!m_valid_reg || m_ready) begin
            out_reg <= fin;
        end else begin
            skid_reg <= fin;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_res_re     = out_reg.re;
    assign m_res_im     = out_reg.im;
    assign m_equal_flag = out_reg.eq;
    assign m_div_zero   = out_reg.dz;
    assign m_overflow   = out_reg.ov;

    `ASSERT_CLK(a_skid_has_out, aclk, aresetn, skid_full_reg |-> m_valid_reg, "skid full with empty output")
    `ASSERT_CLK(a_skid_fill, aclk, aresetn, $rose(skid_full_reg) |-> $past(pv_reg[DEPTH]) && $past(m_valid_reg) && !$past(m_ready), "skid filled without a stalled result")
    `ASSERT_CLK(a_div_zero_res, aclk, aresetn, m_valid && m_div_zero |-> m_res_re == 32'sd0 && m_res_im == 32'sd0 && !m_overflow && !m_equal_flag, "divide by zero result not cleared")
    `ASSERT_CLK(a_ovf_sat, aclk, aresetn, m_valid && m_overflow |-> m_res_re == $signed(cau_pkg::POS_MAX) || m_res_re == $signed(cau_pkg::NEG_MAX) || m_res_im == $signed(cau_pkg::POS_MAX) || m_res_im == $signed(cau_pkg::NEG_MAX), "overflow without a saturated part")

endmodule
